// File: rtl/cetd_pkg.sv
// ----------------------------------------------------------------------------
// cetd_pkg: shared types and constants for the C escape text decoder
// Character codes, decode modes, channel payload structs and helpers.
// ----------------------------------------------------------------------------
package cetd_pkg;

  // Width of the internal decoded byte counter
  localparam int LENGTH_BITS = 16;

  // Width of the reported count and of the max_length register
  localparam int REPORT_BITS = 16;

  // Results one input item can cause: pending number, plain byte, terminator
  localparam int MAX_RESULTS = 3;

  // Character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_V   = 8'h76;
  localparam logic [7:0] CTL_BS       = 8'h08;
  localparam logic [7:0] CTL_FF       = 8'h0C;
  localparam logic [7:0] CTL_LF       = 8'h0A;
  localparam logic [7:0] CTL_CR       = 8'h0D;
  localparam logic [7:0] CTL_HT       = 8'h09;
  localparam logic [7:0] CTL_VT       = 8'h0B;

  // Decoder modes
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_ONE   = 2'd2,
    MODE_TWO   = 2'd3
  } mode_t;

  // Input item
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_in_t;

  // Result item
  typedef struct packed {
    logic [7:0]             plain_byte;
    logic                   is_final;
    logic [REPORT_BITS-1:0] decoded_count;
  } text_out_t;

  // Byte that follows a backslash, when it is not an octal digit
  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_LOWER_B: r = CTL_BS;
      CH_LOWER_F: r = CTL_FF;
      CH_LOWER_N: r = CTL_LF;
      CH_LOWER_R: r = CTL_CR;
      CH_LOWER_T: r = CTL_HT;
      CH_LOWER_V: r = CTL_VT;
      default:    r = b;
    endcase
    return r;
  endfunction

  // Counter value as reported, clamped to the report width
  function automatic logic [REPORT_BITS-1:0] report_count(input logic [LENGTH_BITS-1:0] c);
    logic [32:0] wide;
    logic [32:0] cap;
    wide = 33'(c);
    cap  = {{(33-REPORT_BITS){1'b0}}, {REPORT_BITS{1'b1}}};
    if (wide > cap) begin
      return {REPORT_BITS{1'b1}};
    end
    return REPORT_BITS'(wide);
  endfunction

endpackage

// File: rtl/c_escape_text_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_text_decoder: streaming C escape sequence decoder
// Turns escaped text into plain bytes, one result transfer per cycle while out_ready is high.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : escaped text, one byte per transfer, text_end on the last byte.
//   out_*  : decoded bytes; after the last input one result with is_final
//            set, plain_byte zero and decoded_count holding the length.
//   cfg_*  : writes max_length (0 = unlimited); always ready, write only
//            while the block is idle.
// Timing:
//   An accepted byte is held in the input register, is decoded by
//   the single-pass logic into up to three results held in a result buffer,
//   and the results are offered from that buffer in order. One byte per
//   cycle is sustained when each byte gives at most one result and out_ready
//   stays high; a byte with more results holds the buffer until all are
//   taken, and the input register takes one more byte meanwhile.
// Reset: synchronous rst clears mode, accumulator, counter, max_length and
//   all valid state; no item is pending afterwards.
// Stall: with out_ready low the buffer holds; in_ready drops once the
//   input register is also full.
// ----------------------------------------------------------------------------
module c_escape_text_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cetd_pkg::text_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cetd_pkg::text_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cetd_pkg::REPORT_BITS-1:0]    cfg_data
);
  import cetd_pkg::*;

  // Configuration
  logic [REPORT_BITS-1:0] max_length;

  // Input register
  logic     inq_valid;
  text_in_t inq;

  // Decoder state
  mode_t            mode;
  logic [7:0]       acc;
  logic [LENGTH_BITS-1:0] count;

  // Result buffer
  text_out_t  res [MAX_RESULTS];
  logic [1:0] rem;
  logic [1:0] ptr;

  // Decode results
  mode_t                  mode_next;
  logic [7:0]             acc_next;
  logic [LENGTH_BITS-1:0] count_next;
  text_out_t              res_next [MAX_RESULTS];
  logic [1:0]             rem_next;

  logic load;
  logic out_xfer;

  assign cfg_ready = 1'b1;
  assign out_valid = (rem != 2'd0);
  assign out_data  = res[ptr];
  assign out_xfer  = out_valid && out_ready;
  assign load      = inq_valid && ((rem == 2'd0) || ((rem == 2'd1) && out_ready));
  assign in_ready  = !inq_valid || load;

  // Single-pass decode of the registered byte
  always_comb begin
    logic [7:0]             b;
    logic [7:0]             digit;
    logic                   is_dec;
    logic                   is_oct;
    logic [7:0]             cand [2];
    logic [1:0]             ncand;
    logic [7:0]             acc_dig;
    logic [LENGTH_BITS-1:0] cnt;
    logic [1:0]             k;
    logic                   room;

    b       = inq.text_byte;
    digit   = b - CH_ZERO;
    is_dec  = (b >= CH_ZERO) && (b <= CH_NINE);
    is_oct  = (b >= CH_ZERO) && (b <= CH_SEVEN);
    acc_dig = {acc[4:0], 3'b000} + digit;
    cand[0] = 8'h00;
    cand[1] = 8'h00;
    ncand   = 2'd0;
    mode_next = mode;
    acc_next  = acc;

    case (mode)
      MODE_PLAIN: begin
        if (b == CH_BACKSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          cand[0] = b;
          ncand   = 2'd1;
        end
      end
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (is_oct) begin
          acc_next  = digit;
          mode_next = MODE_ONE;
        end else begin
          cand[0] = escape_map(b);
          ncand   = 2'd1;
        end
      end
      MODE_ONE: begin
        if (is_dec) begin
          acc_next  = acc_dig;
          mode_next = MODE_TWO;
        end else begin
          cand[0] = acc;
          if (b == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
            ncand     = 2'd1;
          end else begin
            mode_next = MODE_PLAIN;
            cand[1]   = b;
            ncand     = 2'd2;
          end
        end
      end
      default: begin
        mode_next = MODE_PLAIN;
        if (is_dec) begin
          acc_next = acc_dig;
          cand[0]  = acc_dig;
          ncand    = 2'd1;
        end else begin
          cand[0] = acc;
          if (b == CH_BACKSLASH) begin
            mode_next = MODE_ESC;
            ncand     = 2'd1;
          end else begin
            cand[1] = b;
            ncand   = 2'd2;
          end
        end
      end
    endcase

    // Number still pending at the end of the string (only with no candidate)
    if (inq.text_end && ((mode_next == MODE_ONE) || (mode_next == MODE_TWO))) begin
      cand[0] = acc_next;
      ncand   = 2'd1;
    end

    // Emit candidates with truncation and counting
    cnt = count;
    k   = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res_next[i] = '0;
    end
    for (int i = 0; i < 2; i++) begin
      room = (max_length == '0) || (32'(cnt) < 32'(max_length));
      if ((2'(i) < ncand) && room) begin
        if (cnt != {LENGTH_BITS{1'b1}}) begin
          cnt = cnt + 1'b1;
        end
        res_next[k].plain_byte    = cand[i];
        res_next[k].is_final      = 1'b0;
        res_next[k].decoded_count = report_count(cnt);
        k = k + 2'd1;
      end
    end

    // Terminating result; state returns to reset values
    if (inq.text_end) begin
      res_next[k].plain_byte    = 8'h00;
      res_next[k].is_final      = 1'b1;
      res_next[k].decoded_count = report_count(cnt);
      k         = k + 2'd1;
      mode_next = MODE_PLAIN;
      acc_next  = 8'h00;
      cnt       = '0;
    end

    count_next = cnt;
    rem_next   = k;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (load) begin
      inq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_data;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_PLAIN;
      acc   <= 8'h00;
      count <= '0;
    end else if (load) begin
      mode  <= mode_next;
      acc   <= acc_next;
      count <= count_next;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      ptr <= 2'd0;
    end else if (load) begin
      rem <= rem_next;
      ptr <= 2'd0;
    end else if (out_xfer) begin
      rem <= rem - 2'd1;
      ptr <= ptr + 2'd1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res[i] <= res_next[i];
      end
    end
  end

endmodule
